### src/ksrm_pkg.sv
// ksrm_pkg: shared types and constants of the keyed set running-max block.
// Holds opcode, status and sequencer encodings and the result record.
// No dependencies.
`default_nettype none

package ksrm_pkg;

   // fixed field widths of the stream payload
   localparam int VALUE_W    = 32;
   localparam int KEY_PORT_W = 16;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_CHANGE = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   // sequencer: clear after reset, then accept / scan rows / drain / hand off
   typedef enum logic [2:0] {
      S_CLEAR  = 3'd0,
      S_IDLE   = 3'd1,
      S_SCAN   = 3'd2,
      S_TAIL   = 3'd3,
      S_FINISH = 3'd4
   } fsm_type;

   typedef struct packed {
      status_type           status;
      logic                 set_nonempty;
      logic [VALUE_W-1:0]   max_value;
   } result_type;

endpackage

`default_nettype wire

### src/ksrm_slot_ram.sv
// ksrm_slot_ram: simple dual-port slot memory, one write and one read port.
// Read data is registered. No dependencies.
`default_nettype none

module ksrm_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 49
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/keyed_set_running_max.sv
// keyed_set_running_max: keyed slot table reporting the max over live entries.
// Items are not overlapped: req_tready is high only in the idle state, so a new item
// waits until the previous one has been scanned and its result loaded. The single
// slot memory read port walks every row once per item, lookup and max together.
// Reset: synchronous; a clearing pass over every row then zeroes every
// live bit, req_tready stays low meanwhile. Reported max resets to zero.
`default_nettype none

module keyed_set_running_max #(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: entry_key[15:0], entry_value[47:16]
   input  wire logic [47:0] req_tdata,
   // req_tuser: opcode[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: max_value[31:0]
   output logic [31:0]      rsp_tdata,
   // rsp_tuser: set_nonempty[0], status[2:1]
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int KW     = (KEY_BITS < ksrm_pkg::KEY_PORT_W) ? KEY_BITS
                                                            : ksrm_pkg::KEY_PORT_W;
   localparam int VW     = ksrm_pkg::VALUE_W;
   localparam int WORD_W = 1 + KW + VW;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   // sequencer and scan control
   ksrm_pkg::fsm_type    fsm_ff, fsm_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;

   // latched request
   ksrm_pkg::opcode_type op_ff;
   logic [KW-1:0]        key_ff;
   logic [VW-1:0]        val_ff;

   // scan accumulators
   logic                 found_ff;
   logic                 any_ff;
   logic [VW-1:0]        best_ff;
   logic [VW-1:0]        last_max_ff;

   // output register
   logic                 rsp_vld_ff;
   ksrm_pkg::result_type rsp_ff;
   ksrm_pkg::result_type rsp_in;

   // memory ports
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic                 mem_re;
   logic [WORD_W-1:0]    mem_rdata;

   // per-row decode
   logic                 row_live;
   logic [KW-1:0]        row_key;
   logic [VW-1:0]        row_val;
   logic                 tgt;
   logic                 post_live;
   logic [KW-1:0]        post_key;
   logic [VW-1:0]        post_val;
   logic                 take;
   logic                 accept;
   logic                 load_rsp;

   ksrm_slot_ram #(
      .DEPTH (TABLE_SLOTS),
      .WIDTH (WORD_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (cnt_ff),
      .rd_data (mem_rdata)
   );

   assign accept = req_tvalid && req_tready;

   // next state and row counter
   always_comb begin
      fsm_in = fsm_ff;
      cnt_in = cnt_ff;
      case (fsm_ff)
         ksrm_pkg::S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in = '0;
               fsm_in = ksrm_pkg::S_IDLE;
            end
         end
         ksrm_pkg::S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               fsm_in = ksrm_pkg::S_SCAN;
            end
         end
         ksrm_pkg::S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in = '0;
               fsm_in = ksrm_pkg::S_TAIL;
            end
         end
         ksrm_pkg::S_TAIL: begin
            fsm_in = ksrm_pkg::S_FINISH;
         end
         ksrm_pkg::S_FINISH: begin
            if (!rsp_vld_ff || rsp_tready) begin
               fsm_in = ksrm_pkg::S_IDLE;
            end
         end
         default: begin
            fsm_in = ksrm_pkg::S_CLEAR;
            cnt_in = '0;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = rd_idx_ff;
      mem_wdata  = {post_live, post_key, post_val};
      load_rsp   = 1'b0;
      case (fsm_ff)
         ksrm_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = '0;
         end
         ksrm_pkg::S_IDLE: begin
            req_tready = 1'b1;
         end
         ksrm_pkg::S_SCAN: begin
            mem_re = 1'b1;
            mem_we = tgt;
         end
         ksrm_pkg::S_TAIL: begin
            mem_we = tgt;
         end
         ksrm_pkg::S_FINISH: begin
            load_rsp = !rsp_vld_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // row decode: target of the operation is the first qualifying row seen
   assign row_live = mem_rdata[WORD_W-1];
   assign row_key  = mem_rdata[VW +: KW];
   assign row_val  = mem_rdata[VW-1:0];

   always_comb begin
      tgt       = 1'b0;
      post_live = row_live;
      post_key  = row_key;
      post_val  = row_val;
      if (rd_vld_ff && !found_ff) begin
         case (op_ff)
            ksrm_pkg::OP_ADD: begin
               if (!row_live) begin
                  tgt       = 1'b1;
                  post_live = 1'b1;
                  post_key  = key_ff;
                  post_val  = val_ff;
               end
            end
            ksrm_pkg::OP_CHANGE: begin
               if (row_live && row_key == key_ff) begin
                  tgt      = 1'b1;
                  post_val = val_ff;
               end
            end
            ksrm_pkg::OP_REMOVE: begin
               if (row_live && row_key == key_ff) begin
                  tgt       = 1'b1;
                  post_live = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // running max over the rows as they stand after the update
   assign take = post_live && (!any_ff || ($signed(post_val) > $signed(best_ff)));

   // result record
   always_comb begin
      rsp_in.max_value    = any_ff ? best_ff : last_max_ff;
      rsp_in.set_nonempty = any_ff;
      case (op_ff)
         ksrm_pkg::OP_ADD: begin
            rsp_in.status = found_ff ? ksrm_pkg::STAT_OK : ksrm_pkg::STAT_FULL;
         end
         ksrm_pkg::OP_CHANGE,
         ksrm_pkg::OP_REMOVE: begin
            rsp_in.status = found_ff ? ksrm_pkg::STAT_OK : ksrm_pkg::STAT_NOT_FOUND;
         end
         default: begin
            rsp_in.status = ksrm_pkg::STAT_OK;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff      <= ksrm_pkg::S_CLEAR;
         cnt_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         any_ff      <= 1'b0;
         last_max_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         fsm_ff    <= fsm_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= mem_re;
         if (accept) begin
            found_ff <= 1'b0;
            any_ff   <= 1'b0;
         end else if (rd_vld_ff) begin
            found_ff <= found_ff | tgt;
            any_ff   <= any_ff | post_live;
         end
         if (load_rsp && any_ff) begin
            last_max_ff <= best_ff;
         end
         if (load_rsp) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff;
      if (accept) begin
         op_ff  <= ksrm_pkg::opcode_type'(req_tuser);
         key_ff <= req_tdata[KW-1:0];
         val_ff <= req_tdata[ksrm_pkg::KEY_PORT_W +: VW];
      end
      if (rd_vld_ff && take) begin
         best_ff <= post_val;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff.max_value;
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.set_nonempty};

   // an accepted beat always starts a row walk
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (fsm_ff == ksrm_pkg::S_SCAN))
      else $error("accepted beat did not start a scan");

   // a full table means something is live
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && rsp_in.status == ksrm_pkg::STAT_FULL) |-> rsp_in.set_nonempty)
      else $error("table full reported with empty set");

   // results only appear out of the hand-off state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(fsm_ff == ksrm_pkg::S_FINISH))
      else $error("result raised outside hand-off");

   // at most one row is modified per item
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff && found_ff) |-> !mem_we)
      else $error("second row written for one item");

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for keyed_set_running_max, driving add/change/remove/nop beats.
// Tracks the keyed table in a scoreboard class and checks every result beat.
// Depends on ksrm_pkg and keyed_set_running_max.

module tb;

   localparam int TABLE_SLOTS = 16;
   localparam int KEY_BITS    = 16;
   localparam int IDLE_LIMIT  = 2000;   // cycles with no beat on either side
   localparam int RANDOM_ITEMS = 1100;

   // tracks the keyed table and the reports it should produce
   class max_table_model;
      logic [31:0] slot_val [TABLE_SLOTS];
      logic [15:0] slot_key [TABLE_SLOTS];
      bit          slot_live [TABLE_SLOTS];
      logic [31:0] held_max;
      ksrm_pkg::result_type pending_reports [$];
      int          mismatches;

      function new();
         foreach (slot_live[i]) begin
            slot_val[i]  = '0;
            slot_key[i]  = '0;
            slot_live[i] = 1'b0;
         end
         held_max   = '0;
         mismatches = 0;
      endfunction

      function int free_slot();
         foreach (slot_live[i])
            if (!slot_live[i]) return i;
         return TABLE_SLOTS;
      endfunction

      // lowest live slot holding the key
      function int match_slot(logic [15:0] key);
         foreach (slot_live[i])
            if (slot_live[i] && slot_key[i] == key) return i;
         return TABLE_SLOTS;
      endfunction

      function int live_count();
         int n;
         n = 0;
         foreach (slot_live[i])
            if (slot_live[i]) n++;
         return n;
      endfunction

      // key of the n-th live slot, counting from slot zero
      function logic [15:0] live_key(int n);
         foreach (slot_live[i]) begin
            if (slot_live[i]) begin
               if (n == 0) return slot_key[i];
               n--;
            end
         end
         return '0;
      endfunction

      // apply one accepted request beat and queue the report it causes
      function void apply_request(ksrm_pkg::opcode_type op, logic [15:0] key,
                                  logic [31:0] val);
         int                   idx;
         bit                   any_live;
         logic [31:0]          best;
         ksrm_pkg::result_type rep;
         rep.status = ksrm_pkg::STAT_OK;
         case (op)
            ksrm_pkg::OP_ADD: begin
               idx = free_slot();
               if (idx < TABLE_SLOTS) begin
                  slot_val[idx]  = val;
                  slot_key[idx]  = key;
                  slot_live[idx] = 1'b1;
               end else begin
                  rep.status = ksrm_pkg::STAT_FULL;
               end
            end
            ksrm_pkg::OP_CHANGE: begin
               idx = match_slot(key);
               if (idx < TABLE_SLOTS) slot_val[idx] = val;
               else rep.status = ksrm_pkg::STAT_NOT_FOUND;
            end
            ksrm_pkg::OP_REMOVE: begin
               idx = match_slot(key);
               if (idx < TABLE_SLOTS) slot_live[idx] = 1'b0;
               else rep.status = ksrm_pkg::STAT_NOT_FOUND;
            end
            default: ;
         endcase
         // max over live slots; an empty table keeps the old max
         any_live = 1'b0;
         best     = '0;
         foreach (slot_live[i]) begin
            if (slot_live[i]) begin
               if (!any_live || $signed(slot_val[i]) > $signed(best)) best = slot_val[i];
               any_live = 1'b1;
            end
         end
         if (any_live) held_max = best;
         rep.max_value    = held_max;
         rep.set_nonempty = any_live;
         pending_reports.insert(pending_reports.size(), rep);
      endfunction

      // compare one result beat with the oldest queued report
      function void compare_report(logic [31:0] data, logic [2:0] user);
         ksrm_pkg::result_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result beat with nothing expected: max %h nonempty %0d status %0d",
                        data, user[0], user[2:1]);
            return;
         end
         want = pending_reports.pop_front();
         if (data !== want.max_value || user[0] !== want.set_nonempty ||
             user[2:1] !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected max %h nonempty %0d status %0d, ",
                         "got max %h nonempty %0d status %0d"},
                        want.max_value, want.set_nonempty, want.status,
                        data, user[0], user[2:1]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic [47:0] req_tdata;   // entry_key[15:0], entry_value[47:16]
   logic [1:0]  req_tuser;   // opcode[1:0]
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] rsp_tdata;   // max_value[31:0]
   logic [2:0]  rsp_tuser;   // set_nonempty[0], status[2:1]
   logic        rsp_tvalid;
   logic        rsp_tready;

   max_table_model tracker = new();
   int items_sent = 0;
   int idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keyed_set_running_max #(
      .TABLE_SLOTS(TABLE_SLOTS),
      .KEY_BITS   (KEY_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   // idle stretch: mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // operand values: extremes now and then, otherwise anything
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   // live keys for hits, a small pool for duplicates, full range otherwise
   function automatic logic [15:0] pick_key(bit want_live);
      int live_n, r;
      live_n = tracker.live_count();
      r = $urandom_range(0, 99);
      if (live_n > 0 && (want_live ? r < 85 : r < 20))
         return tracker.live_key($urandom_range(0, live_n - 1));
      if (r % 2) return 16'($urandom_range(0, 7));
      return 16'($urandom);
   endfunction

   // steer the fill level toward fill_goal, with some noise mixed in
   task automatic choose_item(input int fill_goal, output ksrm_pkg::opcode_type op,
                              output logic [15:0] key, output logic [31:0] val);
      int live_n, r;
      live_n = tracker.live_count();
      r = $urandom_range(0, 99);
      val = pick_value();
      if (r < 4) begin
         op  = ksrm_pkg::OP_NOP;
         key = 16'($urandom);
      end else if (r < 9) begin
         op  = ksrm_pkg::opcode_type'($urandom_range(0, 3));
         key = 16'($urandom);
      end else begin
         r = $urandom_range(0, 99);
         if (live_n < fill_goal)
            op = (r < 70) ? ksrm_pkg::OP_ADD :
                 (r < 85) ? ksrm_pkg::OP_CHANGE : ksrm_pkg::OP_REMOVE;
         else if (live_n > fill_goal)
            op = (r < 65) ? ksrm_pkg::OP_REMOVE :
                 (r < 85) ? ksrm_pkg::OP_CHANGE : ksrm_pkg::OP_ADD;
         else
            op = (r < 50) ? ksrm_pkg::OP_CHANGE :
                 (r < 75) ? ksrm_pkg::OP_ADD : ksrm_pkg::OP_REMOVE;
         key = pick_key(op != ksrm_pkg::OP_ADD);
      end
   endtask

   // drive one request beat and wait for it to be taken
   task automatic send_item(input ksrm_pkg::opcode_type op, input logic [15:0] key,
                            input logic [31:0] val);
      int gap;
      gap = 0;
      if ((items_sent / 120) % 5 != 3 && $urandom_range(0, 99) < 35) gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {val, key};
      do @(posedge clock); while (!req_tready);
      tracker.apply_request(op, key, val);
      items_sent++;
   endtask

   // result side: check accepted beats, stall at random
   initial begin
      int stall_left;
      int cyc;
      stall_left = 0;
      cyc = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (!reset && rsp_tvalid && rsp_tready) tracker.compare_report(rsp_tdata, rsp_tuser);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ((cyc / 300) % 4 != 2 && $urandom_range(0, 99) < 25) stall_left = idle_len();
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                   fill_goal;
      ksrm_pkg::opcode_type op;
      logic [15:0]          key;
      logic [31:0]          val;
      fill_goal = 8;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ksrm_pkg::OP_NOP;
      req_tdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty after reset, misses on empty table, empty after remove
      send_item(ksrm_pkg::OP_NOP,    16'h0000, 32'h1234_5678);
      send_item(ksrm_pkg::OP_REMOVE, 16'h1234, 32'h0000_0000);
      send_item(ksrm_pkg::OP_CHANGE, 16'hFFFF, 32'h7FFF_FFFF);
      send_item(ksrm_pkg::OP_ADD,    16'h0000, 32'h8000_0000);
      send_item(ksrm_pkg::OP_REMOVE, 16'h0000, 32'hFFFF_FFFF);
      // value extremes, duplicate keys, change and remove hitting the lowest slot
      send_item(ksrm_pkg::OP_ADD,    16'hFFFF, 32'h7FFF_FFFF);
      send_item(ksrm_pkg::OP_ADD,    16'h00AA, 32'h0000_0000);
      send_item(ksrm_pkg::OP_ADD,    16'h00AA, 32'hFFFF_FFFF);
      send_item(ksrm_pkg::OP_CHANGE, 16'h00AA, 32'h0001_0000);
      send_item(ksrm_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000);
      // fill to the top, then one add into a full table
      for (int i = 0; i < TABLE_SLOTS - 2; i++)
         send_item(ksrm_pkg::OP_ADD, 16'h5A00 + 16'(i), $urandom);
      send_item(ksrm_pkg::OP_ADD, 16'h5AFF, 32'h7FFF_FFFF);

      // random: fill level wanders between empty and full
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 5))
               0: fill_goal = 0;
               1: fill_goal = TABLE_SLOTS;
               default: fill_goal = $urandom_range(1, TABLE_SLOTS - 1);
            endcase
         end
         // now and then hold off until every report is back
         if (n % 250 == 125 && tracker.pending_reports.size() != 0) begin
            req_tvalid <= 1'b0;
            while (tracker.pending_reports.size() != 0) @(posedge clock);
         end
         choose_item(fill_goal, op, key, val);
         send_item(op, key, val);
      end
      req_tvalid <= 1'b0;

      // drain, then watch for stray beats
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
